[hw/rtl/stereo_feedback_delay_defines.svh]
// assertion macros for the stereo feedback delay block
// no dependencies; included by the top level only
`ifndef STEREO_FEEDBACK_DELAY_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// plain property, checked at every clock edge outside reset
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, checked at every clock edge outside reset
`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define SFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/sfd_pkg.sv]
// shared types and constants of the stereo feedback delay
// no dependencies; used by every module of the block but sfd_ram
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // delay line geometry
  localparam int unsigned DelayDepth = 65536;
  localparam int unsigned AddrW      = $clog2(DelayDepth);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned MemW       = 2 * SampleW;

  // control word formats
  localparam int unsigned FracW      = 17;  // delay fraction, 0..65536
  localparam int unsigned GainW      = 16;  // Q1.15 gain, 0..32768

  // configuration register widths
  localparam int unsigned DelayBaseW = 17;
  localparam int unsigned DelayOffW  = 18;
  localparam int unsigned GainBaseW  = 16;
  localparam int unsigned GainOffW   = 17;
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned CfgIdxW    = 3;

  // reset values of the configuration registers
  localparam logic [DelayBaseW-1:0] DelayBaseRst = DelayBaseW'(16384);
  localparam logic [GainBaseW-1:0]  GainBaseRst  = GainBaseW'(16384);

  typedef logic [AddrW-1:0] addr_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDelayBase   = 3'd0,
    CfgDelayOffset = 3'd1,
    CfgFbBase      = 3'd2,
    CfgFbOffset    = 3'd3,
    CfgMixBase     = 3'd4,
    CfgMixOffset   = 3'd5
  } cfg_idx_e;

  // request payloads
  typedef struct packed {
    logic signed [SampleW-1:0] in_left;
    logic signed [SampleW-1:0] in_right;
  } sfd_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
  } sfd_out_t;

  // derived controls from the register file
  typedef struct packed {
    addr_t             delay;
    logic [GainW-1:0]  fb;
    logic [GainW-1:0]  mx;
  } sfd_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sfd_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned DataW = 1,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/sfd_cfg.sv]
// configuration registers and derived delay, feedback and mix controls
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sfd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output      sfd_pkg::sfd_ctl_t             ctl_o
);

  localparam int unsigned DelaySumW = sfd_pkg::DelayOffW + 1;
  localparam int unsigned GainSumW  = sfd_pkg::GainOffW + 1;
  localparam int unsigned ProdW     = sfd_pkg::FracW + $clog2(sfd_pkg::DelayDepth + 1);
  localparam logic [sfd_pkg::GainW-1:0] GainOne = sfd_pkg::GainW'(32768);
  localparam logic [sfd_pkg::FracW-1:0] FracOne = sfd_pkg::FracW'(65536);

  logic [sfd_pkg::DelayBaseW-1:0] delay_base_q;
  logic [sfd_pkg::DelayOffW-1:0]  delay_off_q;
  logic [sfd_pkg::GainBaseW-1:0]  fb_base_q;
  logic [sfd_pkg::GainOffW-1:0]   fb_off_q;
  logic [sfd_pkg::GainBaseW-1:0]  mix_base_q;
  logic [sfd_pkg::GainOffW-1:0]   mix_off_q;

  logic signed [DelaySumW-1:0]    delay_sum;
  logic [sfd_pkg::FracW-1:0]      frac;
  logic [ProdW-1:0]               delay_prod;
  logic [ProdW-1:0]               delay_wide;

  // base plus signed offset, clamped to 0..one
  function automatic logic [sfd_pkg::GainW-1:0] clamp_gain(
    input logic [sfd_pkg::GainBaseW-1:0] base,
    input logic [sfd_pkg::GainOffW-1:0]  off
  );
    logic signed [GainSumW-1:0] sum;
    logic [sfd_pkg::GainW-1:0]  res;
    sum = $signed({2'b00, base}) + $signed({off[sfd_pkg::GainOffW-1], off});
    if (sum < 0) begin
      res = '0;
    end else if (sum > $signed(GainSumW'(GainOne))) begin
      res = GainOne;
    end else begin
      res = sum[sfd_pkg::GainW-1:0];
    end
    return res;
  endfunction

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_base_q <= sfd_pkg::DelayBaseRst;
      delay_off_q  <= '0;
      fb_base_q    <= sfd_pkg::GainBaseRst;
      fb_off_q     <= '0;
      mix_base_q   <= sfd_pkg::GainBaseRst;
      mix_off_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (sfd_pkg::cfg_idx_e'(cfg_idx_i))
        sfd_pkg::CfgDelayBase:   delay_base_q <= cfg_wdata_i[sfd_pkg::DelayBaseW-1:0];
        sfd_pkg::CfgDelayOffset: delay_off_q  <= cfg_wdata_i[sfd_pkg::DelayOffW-1:0];
        sfd_pkg::CfgFbBase:      fb_base_q    <= cfg_wdata_i[sfd_pkg::GainBaseW-1:0];
        sfd_pkg::CfgFbOffset:    fb_off_q     <= cfg_wdata_i[sfd_pkg::GainOffW-1:0];
        sfd_pkg::CfgMixBase:     mix_base_q   <= cfg_wdata_i[sfd_pkg::GainBaseW-1:0];
        sfd_pkg::CfgMixOffset:   mix_off_q    <= cfg_wdata_i[sfd_pkg::GainOffW-1:0];
        default: ;
      endcase
    end
  end

  // delay fraction clamp, scale to the buffer, limit to depth minus one; gains
  always_comb begin
    delay_sum = $signed({2'b00, delay_base_q}) +
                $signed({delay_off_q[sfd_pkg::DelayOffW-1], delay_off_q});
    if (delay_sum < 0) begin
      frac = '0;
    end else if (delay_sum > $signed(DelaySumW'(FracOne))) begin
      frac = FracOne;
    end else begin
      frac = delay_sum[sfd_pkg::FracW-1:0];
    end
    delay_prod = ProdW'(frac) * ProdW'(sfd_pkg::DelayDepth);
    delay_wide = delay_prod >> 16;
    if (delay_wide > ProdW'(sfd_pkg::DelayDepth - 1)) begin
      ctl_o.delay = sfd_pkg::AddrW'(sfd_pkg::DelayDepth - 1);
    end else begin
      ctl_o.delay = delay_wide[sfd_pkg::AddrW-1:0];
    end
    ctl_o.fb = clamp_gain(fb_base_q, fb_off_q);
    ctl_o.mx = clamp_gain(mix_base_q, mix_off_q);
  end

endmodule

`default_nettype wire

[hw/rtl/sfd_mix.sv]
// one channel of the mix and feedback arithmetic: product stage, then sums
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_mix (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [sfd_pkg::SampleW-1:0]  dry_i,
  input  wire logic signed [sfd_pkg::SampleW-1:0]  wet_i,
  input  wire logic [sfd_pkg::GainW-1:0]           fb_i,
  input  wire logic [sfd_pkg::GainW-1:0]           mx_i,
  output      logic signed [sfd_pkg::SampleW-1:0]  out_o,
  output      logic signed [sfd_pkg::SampleW-1:0]  store_o
);

  localparam int unsigned GainSW = sfd_pkg::GainW + 1;
  localparam int unsigned ProdW  = sfd_pkg::SampleW + GainSW;
  localparam int unsigned ShW    = ProdW - 15;
  localparam int unsigned SumW   = ShW + 1;
  localparam logic [sfd_pkg::GainW-1:0] GainOne = sfd_pkg::GainW'(32768);

  logic signed [GainSW-1:0]           inv_s;
  logic signed [GainSW-1:0]           mx_s;
  logic signed [GainSW-1:0]           fb_s;
  logic signed [ProdW-1:0]            p_dry_d, p_dry_q;
  logic signed [ProdW-1:0]            p_wet_d, p_wet_q;
  logic signed [ProdW-1:0]            p_fb_d,  p_fb_q;
  logic signed [sfd_pkg::SampleW-1:0] dry_q;
  logic signed [ShW-1:0]              sh_dry, sh_wet, sh_fb;

  function automatic logic signed [sfd_pkg::SampleW-1:0] sat16(
    input logic signed [SumW-1:0] x
  );
    logic signed [sfd_pkg::SampleW-1:0] res;
    if (x > $signed(SumW'(32767))) begin
      res = 16'sh7fff;
    end else if (x < -$signed(SumW'(32768))) begin
      res = 16'sh8000;
    end else begin
      res = x[sfd_pkg::SampleW-1:0];
    end
    return res;
  endfunction

  // gains as signed operands
  assign inv_s = $signed({1'b0, GainOne - mx_i});
  assign mx_s  = $signed({1'b0, mx_i});
  assign fb_s  = $signed({1'b0, fb_i});

  // products
  assign p_dry_d = ProdW'(dry_i) * ProdW'(inv_s);
  assign p_wet_d = ProdW'(wet_i) * ProdW'(mx_s);
  assign p_fb_d  = ProdW'(wet_i) * ProdW'(fb_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_dry_q <= p_dry_d;
      p_wet_q <= p_wet_d;
      p_fb_q  <= p_fb_d;
      dry_q   <= dry_i;
    end
  end

  // drop 15 fraction bits, rounding toward minus infinity
  assign sh_dry = p_dry_q[ProdW-1:15];
  assign sh_wet = p_wet_q[ProdW-1:15];
  assign sh_fb  = p_fb_q[ProdW-1:15];

  // mixed output and value fed back into the line
  assign out_o   = sat16(SumW'(sh_dry) + SumW'(sh_wet));
  assign store_o = sat16(SumW'(dry_q) + SumW'(sh_fb));

endmodule

`default_nettype wire

[hw/rtl/stereo_feedback_delay.sv]
// stereo feedback delay with dry/wet mix: top level and pipeline control
// depends on sfd_pkg, sfd_cfg, sfd_ram, sfd_mix and the defines header
//
//   channel  | signals                          | accepted when
//   ---------+----------------------------------+---------------------------
//   input    | in_valid_i in_ready_o in_data_i  | in_valid_i and in_ready_o
//   output   | out_valid_o out_ready_i out_data_o | out_valid_o and out_ready_i
//   config   | cfg_we_i cfg_idx_i cfg_wdata_i   | cfg_we_i
//
// one request per cycle sustained while the output drains and no interlock
// holds the input; a result reaches the output register through the ram read
// at the accepting edge, the product stage, then the sum stage that loads it.
// with a delay of one or two frames the read waits for the pending write of
// the same entry, so a request may be held off until that write is done.
// unwritten line entries read as zero through a wrap flag and the write
// position; no clearing pass after reset. a stalled output fills the
// pipeline before the input side stops.
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_feedback_delay_defines.svh"

module stereo_feedback_delay (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire sfd_pkg::sfd_in_t              in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      sfd_pkg::sfd_out_t             out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sfd_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam sfd_pkg::addr_t WpMax = sfd_pkg::AddrW'(sfd_pkg::DelayDepth - 1);

  sfd_pkg::sfd_ctl_t ctl;

  // write position and wrap flag
  sfd_pkg::addr_t wp_d, wp_q;
  logic           wrapped_d, wrapped_q;

  // read address of the arriving request
  sfd_pkg::addr_t rd;
  logic           rd_hit;
  logic           hazard;
  logic           in_acc;

  // stage 1: ram read in flight
  logic                         s1_v_d, s1_v_q;
  sfd_pkg::addr_t               s1_wp_q, s1_rd_q;
  logic                         s1_hit_q;
  sfd_pkg::sfd_in_t             s1_dry_q;
  logic [sfd_pkg::GainW-1:0]    s1_fb_q, s1_mx_q;
  logic                         s1_go;

  // stage 2: products registered
  logic                         s2_v_d, s2_v_q;
  sfd_pkg::addr_t               s2_wp_q;
  logic                         s2_go;

  // output register
  logic                         out_v_d, out_v_q;
  sfd_pkg::sfd_out_t            out_q;

  logic [sfd_pkg::MemW-1:0]     ram_rdata;
  logic [sfd_pkg::MemW-1:0]     ram_wdata;
  logic signed [sfd_pkg::SampleW-1:0] wet_l, wet_r;
  logic signed [sfd_pkg::SampleW-1:0] mix_l, mix_r, store_l, store_r;

  sfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_o       (ctl)
  );

  // read address behind the write position, wrapping at the depth
  always_comb begin
    if (wp_q >= ctl.delay) begin
      rd = wp_q - ctl.delay;
    end else begin
      rd = sfd_pkg::AddrW'((sfd_pkg::AddrW + 1)'(wp_q) +
                           (sfd_pkg::AddrW + 1)'(sfd_pkg::DelayDepth) -
                           (sfd_pkg::AddrW + 1)'(ctl.delay));
    end
  end

  // an entry holds data once written; before the first wrap only lower ones
  assign rd_hit = wrapped_q || (rd < wp_q);

  // interlock: entry still owed a write by a request in flight
  assign hazard = (s1_v_q && (s1_wp_q == rd)) || (s2_v_q && (s2_wp_q == rd));

  // pipeline handshake
  assign s2_go      = s2_v_q && (!out_v_q || out_ready_i);
  assign s1_go      = s1_v_q && (!s2_v_q || s2_go);
  assign in_ready_o = (!s1_v_q || s1_go) && !hazard;
  assign in_acc     = in_valid_i && in_ready_o;

  // valid bits
  always_comb begin
    s1_v_d  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
    s2_v_d  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_q);
    out_v_d = s2_go ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
  end

  // write position advance
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (in_acc) begin
      if (wp_q == WpMax) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_wp_q  <= wp_q;
      s1_rd_q  <= rd;
      s1_hit_q <= rd_hit;
      s1_dry_q <= in_data_i;
      s1_fb_q  <= ctl.fb;
      s1_mx_q  <= ctl.mx;
    end
    if (s1_go) begin
      s2_wp_q <= s1_wp_q;
    end
    if (s2_go) begin
      out_q.out_left  <= mix_l;
      out_q.out_right <= mix_r;
    end
  end

  // delay line storage
  assign ram_wdata = {store_r, store_l};

  sfd_ram #(
    .Depth (sfd_pkg::DelayDepth),
    .DataW (sfd_pkg::MemW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s2_go),
    .waddr_i (s2_wp_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (rd),
    .rdata_o (ram_rdata)
  );

  // delayed samples, zero where the entry was never written
  assign wet_l = s1_hit_q ? $signed(ram_rdata[sfd_pkg::SampleW-1:0]) : '0;
  assign wet_r = s1_hit_q ? $signed(ram_rdata[sfd_pkg::MemW-1:sfd_pkg::SampleW]) : '0;

  sfd_mix u_mix_l (
    .clk_i   (clk_i),
    .en_i    (s1_go),
    .dry_i   (s1_dry_q.in_left),
    .wet_i   (wet_l),
    .fb_i    (s1_fb_q),
    .mx_i    (s1_mx_q),
    .out_o   (mix_l),
    .store_o (store_l)
  );

  sfd_mix u_mix_r (
    .clk_i   (clk_i),
    .en_i    (s1_go),
    .dry_i   (s1_dry_q.in_right),
    .wet_i   (wet_r),
    .fb_i    (s1_fb_q),
    .mx_i    (s1_mx_q),
    .out_o   (mix_r),
    .store_o (store_r)
  );

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  `SFD_ASSERT_IMPL(a_no_stale_read, clk_i, rst_ni, s2_go && s1_v_q, s1_rd_q != s2_wp_q, "read overtook a pending write of the same entry")
  `SFD_ASSERT_IMPL(a_wp_step, clk_i, rst_ni, $past(in_acc) && $past(rst_ni), wp_q == (($past(wp_q) == WpMax) ? '0 : $past(wp_q) + 1'b1), "write position did not step once per request")
  `SFD_ASSERT_IMPL(a_out_from_s2, clk_i, rst_ni, $rose(out_v_q), $past(s2_go), "result appeared without a sum stage transfer")
  `SFD_ASSERT(a_write_order, clk_i, rst_ni, !(s1_v_q && s2_v_q) || (s1_wp_q == s2_wp_q + 1'b1) || (s2_wp_q == WpMax && s1_wp_q == '0), "stages hold non-consecutive write positions")

endmodule

`default_nettype wire
